// ===== rtl/i2cram_pkg.sv =====
package i2cram_pkg;

   // largest byte count that a begin request may carry
   localparam int unsigned MAX_BYTES = 256;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_BYTE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_IDLE     = 3'd0,
      STAT_BUSY     = 3'd1,
      STAT_DONE_OK  = 3'd2,
      STAT_DONE_NAK = 3'd3,
      STAT_REJECTED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_FREE = 2'd2
   } sda_type;

   // what the byte on the wire is for
   typedef enum logic [2:0] {
      ROLE_DEVW  = 3'd0,
      ROLE_REGHI = 3'd1,
      ROLE_REGLO = 3'd2,
      ROLE_DEVR  = 3'd3,
      ROLE_DATA  = 3'd4
   } role_type;

   typedef enum logic [14:0] {
      PH_IDLE      = 15'b000000000000001,
      PH_START_A   = 15'b000000000000010,
      PH_START_B   = 15'b000000000000100,
      PH_WBIT_LOW  = 15'b000000000001000,
      PH_WBIT_HIGH = 15'b000000000010000,
      PH_WACK_LOW  = 15'b000000000100000,
      PH_WACK_HIGH = 15'b000000001000000,
      PH_WACK_TAIL = 15'b000000010000000,
      PH_RBIT_LOW  = 15'b000000100000000,
      PH_RBIT_HIGH = 15'b000001000000000,
      PH_RACK_LOW  = 15'b000010000000000,
      PH_RACK_HIGH = 15'b000100000000000,
      PH_STOP_A    = 15'b001000000000000,
      PH_STOP_B    = 15'b010000000000000,
      PH_STOP_C    = 15'b100000000000000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_counter;
      logic [7:0] shifter;
      logic [8:0] bytes_left;
      logic [6:0] target_device;
      logic [15:0] target_register;
      logic       wide_address;
      logic       is_read;
      logic       nack_seen;
      logic       scl_state;
      sda_type    sda_state;
      logic       byte_pending;
      role_type   role;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_IDLE,
      bit_counter:     4'd0,
      shifter:         8'd0,
      bytes_left:      9'd0,
      target_device:   7'd0,
      target_register: 16'd0,
      wide_address:    1'b0,
      is_read:         1'b0,
      nack_seen:       1'b0,
      scl_state:       1'b1,
      sda_state:       SDA_HIGH,
      byte_pending:    1'b0,
      role:            ROLE_DEVW
   };

   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  device_address;
      logic [15:0] register_address;
      logic        addr_16bit;
      logic [8:0]  byte_count;
      logic [7:0]  write_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic [1:0] sda_mode;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       want_write_byte;
      logic [2:0] status;
   } rsp_type;

   // load a byte into the shifter and put its first bit on sda
   function automatic state_type send_byte(state_type s, logic [7:0] value, role_type which);
      state_type n;
      n             = s;
      n.shifter     = value;
      n.role        = which;
      n.bit_counter = 4'd1;
      n.sda_state   = value[7] ? SDA_HIGH : SDA_LOW;
      n.phase       = PH_WBIT_LOW;
      return n;
   endfunction

   function automatic state_type go_stop(state_type s);
      state_type n;
      n           = s;
      n.sda_state = SDA_LOW;
      n.phase     = PH_STOP_A;
      return n;
   endfunction

   function automatic state_type go_read_byte(state_type s);
      state_type n;
      n             = s;
      n.sda_state   = SDA_FREE;
      n.shifter     = 8'd0;
      n.bit_counter = 4'd0;
      n.phase       = PH_RBIT_LOW;
      return n;
   endfunction

   // next write data byte, stop, or hold in the tail until one is buffered
   function automatic state_type next_data(state_type s, logic [7:0] pend);
      state_type n;
      n = s;
      if (s.bytes_left == 9'd0) begin
         n = go_stop(s);
      end else if (s.byte_pending) begin
         n.byte_pending = 1'b0;
         n.bytes_left   = s.bytes_left - 9'd1;
         n              = send_byte(n, pend, ROLE_DATA);
      end
      return n;
   endfunction

   function automatic state_type after_ack(state_type s, logic [7:0] pend);
      state_type n;
      n = s;
      if (s.nack_seen) begin
         n = go_stop(s);
      end else begin
         case (s.role)
            ROLE_DEVW: begin
               if (s.wide_address) begin
                  n = send_byte(s, s.target_register[15:8], ROLE_REGHI);
               end else begin
                  n = send_byte(s, s.target_register[7:0], ROLE_REGLO);
               end
            end
            ROLE_REGHI: n = send_byte(s, s.target_register[7:0], ROLE_REGLO);
            ROLE_REGLO: begin
               if (s.is_read) begin
                  n.sda_state = SDA_HIGH;
                  n.scl_state = 1'b1;
                  n.role      = ROLE_DEVR;
                  n.phase     = PH_START_A;
               end else begin
                  n = next_data(s, pend);
               end
            end
            ROLE_DEVR: n = go_read_byte(s);
            default:   n = next_data(s, pend);
         endcase
      end
      return n;
   endfunction

   function automatic logic wants_byte(state_type s);
      return s.phase != PH_IDLE && s.phase != PH_STOP_A && s.phase != PH_STOP_B &&
             s.phase != PH_STOP_C && !s.is_read && !s.nack_seen &&
             s.bytes_left != 9'd0 && !s.byte_pending;
   endfunction

endpackage

// ===== rtl/i2cram_req_if.sv =====
interface i2cram_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [6:0]  device_address;
   logic [15:0] register_address;
   logic        addr_16bit;
   logic [8:0]  byte_count;
   logic [7:0]  write_data;
   logic        sda_in;

   modport source (
      output valid, mode, device_address, register_address, addr_16bit,
             byte_count, write_data, sda_in,
      input  ready
   );
   modport sink (
      input  valid, mode, device_address, register_address, addr_16bit,
             byte_count, write_data, sda_in,
      output ready
   );
endinterface

// ===== rtl/i2cram_rsp_if.sv =====
interface i2cram_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic [1:0] sda_mode;
   logic [7:0] read_data;
   logic       read_valid;
   logic       read_last;
   logic       want_write_byte;
   logic [2:0] status;

   modport source (
      output valid, scl_level, sda_mode, read_data, read_valid, read_last,
             want_write_byte, status,
      input  ready
   );
   modport sink (
      input  valid, scl_level, sda_mode, read_data, read_valid, read_last,
             want_write_byte, status,
      output ready
   );
endinterface

// ===== rtl/i2cram_step.sv =====
module i2cram_step (
   input  i2cram_pkg::state_type st,
   input  logic [7:0]            pending_byte,
   input  i2cram_pkg::req_type   req,
   output i2cram_pkg::state_type st_in,
   output logic                  pend_we,
   output i2cram_pkg::rsp_type   rsp
);
   import i2cram_pkg::*;

   state_type  n;
   status_type stat;
   logic       finished;
   logic       rvalid;
   logic       rlast;
   logic [7:0] rdata;
   logic [7:0] shifted;
   logic [3:0] bits_next;
   logic       rejected;

   assign shifted   = {st.shifter[6:0], 1'b0};
   assign bits_next = st.bit_counter + 4'd1;
   assign rejected  = req.byte_count == 9'd0 || req.byte_count > 9'(MAX_BYTES);

   // one bus step per tick beat; a begin beat starts a transaction, a byte beat buffers write data
   always_comb begin
      n        = st;
      pend_we  = 1'b0;
      finished = 1'b0;
      rvalid   = 1'b0;
      rlast    = 1'b0;
      rdata    = 8'd0;
      stat     = STAT_IDLE;
      case (mode_type'(req.mode))
         MODE_WRITE, MODE_READ: begin
            if (st.phase == PH_IDLE) begin
               if (rejected) begin
                  stat = STAT_REJECTED;
               end else begin
                  n.target_device   = req.device_address;
                  n.target_register = req.register_address;
                  n.wide_address    = req.addr_16bit;
                  n.is_read         = req.mode == MODE_READ;
                  n.bytes_left      = req.byte_count;
                  n.nack_seen       = 1'b0;
                  n.byte_pending    = 1'b0;
                  n.role            = ROLE_DEVW;
                  n.sda_state       = SDA_HIGH;
                  n.scl_state       = 1'b1;
                  n.phase           = PH_START_A;
               end
            end
         end
         MODE_BYTE: begin
            if (wants_byte(st)) begin
               pend_we        = 1'b1;
               n.byte_pending = 1'b1;
            end
         end
         default: begin
            case (st.phase)
               PH_START_A: begin
                  n.sda_state = SDA_LOW;
                  n.phase     = PH_START_B;
               end
               PH_START_B: begin
                  n.scl_state = 1'b0;
                  if (st.role == ROLE_DEVR) begin
                     n = send_byte(n, {st.target_device, 1'b1}, ROLE_DEVR);
                  end else begin
                     n = send_byte(n, {st.target_device, 1'b0}, ROLE_DEVW);
                  end
               end
               PH_WBIT_LOW: begin
                  n.scl_state = 1'b1;
                  n.phase     = PH_WBIT_HIGH;
               end
               PH_WBIT_HIGH: begin
                  n.scl_state = 1'b0;
                  if (st.bit_counter < 4'd8) begin
                     n.shifter     = shifted;
                     n.sda_state   = shifted[7] ? SDA_HIGH : SDA_LOW;
                     n.bit_counter = bits_next;
                     n.phase       = PH_WBIT_LOW;
                  end else begin
                     n.sda_state = SDA_FREE;
                     n.phase     = PH_WACK_LOW;
                  end
               end
               PH_WACK_LOW: begin
                  n.scl_state = 1'b1;
                  n.phase     = PH_WACK_HIGH;
               end
               PH_WACK_HIGH: begin
                  if (req.sda_in) begin
                     n.nack_seen = 1'b1;
                  end
                  n.scl_state = 1'b0;
                  n.sda_state = SDA_HIGH;
                  n.phase     = PH_WACK_TAIL;
               end
               PH_WACK_TAIL: n = after_ack(st, pending_byte);
               PH_RBIT_LOW: begin
                  n.scl_state = 1'b1;
                  n.phase     = PH_RBIT_HIGH;
               end
               PH_RBIT_HIGH: begin
                  n.shifter     = {st.shifter[6:0], req.sda_in};
                  n.scl_state   = 1'b0;
                  n.bit_counter = bits_next;
                  if (bits_next < 4'd8) begin
                     n.phase = PH_RBIT_LOW;
                  end else begin
                     n.sda_state = (st.bytes_left <= 9'd1) ? SDA_HIGH : SDA_LOW;
                     n.phase     = PH_RACK_LOW;
                  end
               end
               PH_RACK_LOW: begin
                  n.scl_state = 1'b1;
                  n.phase     = PH_RACK_HIGH;
               end
               PH_RACK_HIGH: begin
                  n.scl_state = 1'b0;
                  n.sda_state = SDA_HIGH;
                  rvalid      = 1'b1;
                  rdata       = st.shifter;
                  rlast       = st.bytes_left <= 9'd1;
                  if (st.bytes_left > 9'd1) begin
                     n.bytes_left = st.bytes_left - 9'd1;
                     n            = go_read_byte(n);
                  end else begin
                     n.bytes_left = 9'd0;
                     n            = go_stop(n);
                  end
               end
               PH_STOP_A: begin
                  n.scl_state = 1'b1;
                  n.phase     = PH_STOP_B;
               end
               PH_STOP_B: begin
                  n.sda_state = SDA_HIGH;
                  n.phase     = PH_STOP_C;
               end
               PH_STOP_C: begin
                  n.phase  = PH_IDLE;
                  finished = 1'b1;
               end
               default: n.phase = PH_IDLE;
            endcase
         end
      endcase

      // status after the step
      if (finished) begin
         stat = n.nack_seen ? STAT_DONE_NAK : STAT_DONE_OK;
      end else if (n.phase != PH_IDLE) begin
         stat = STAT_BUSY;
      end
   end

   assign st_in = n;

   assign rsp.scl_level       = n.scl_state;
   assign rsp.sda_mode        = n.sda_state;
   assign rsp.read_data       = rdata;
   assign rsp.read_valid      = rvalid;
   assign rsp.read_last       = rlast;
   assign rsp.want_write_byte = wants_byte(n);
   assign rsp.status          = stat;

endmodule

// ===== rtl/i2c_register_access_master_unit.sv =====
// I2C / SCCB register access master, stepped one bus half-period per request beat.
// req_chan: mode 0 is a half-period tick (sda_in is the line level sampled in it),
//   mode 1 / 2 begin a write / read with device address, register address,
//   address width and byte count, mode 3 hands over the next write data byte.
// rsp_chan: exactly one beat per request beat, in order, carrying the scl level,
//   sda drive mode, any received byte, the write-byte request flag and status.
// A request beat is taken into a single request register feeding the step logic,
//   which updates the bus state and writes the response register together;
//   one request beat per cycle is sustained while responses are taken.
// A stalled response holds in its register; the request register still takes
//   one more beat, then ready drops until the response is taken.
// Reset: bus idle, scl high and sda driven high, no beats held.
// Write data is asked for through want_write_byte; when it has not come by the
//   time it is needed the bus holds with scl low until a mode 3 beat supplies it.
module i2c_register_access_master_unit (
   input logic          clock,
   input logic          reset,
   i2cram_req_if.sink   req_chan,
   i2cram_rsp_if.source rsp_chan
);
   import i2cram_pkg::*;

   logic      req_v_ff;
   req_type   req_ff;
   logic      rsp_v_ff;
   logic      rsp_v_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   state_type st_ff;
   state_type st_in;
   logic [7:0] pend_ff;
   logic       pend_we;
   logic       advance;

   // step fires when a request is held and the response slot is free
   assign advance          = req_v_ff && (!rsp_v_ff || rsp_chan.ready);
   assign req_chan.ready   = !req_v_ff || advance;
   assign rsp_v_in         = advance || (rsp_v_ff && !rsp_chan.ready);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_ff.mode             <= req_chan.mode;
         req_ff.device_address   <= req_chan.device_address;
         req_ff.register_address <= req_chan.register_address;
         req_ff.addr_16bit       <= req_chan.addr_16bit;
         req_ff.byte_count       <= req_chan.byte_count;
         req_ff.write_data       <= req_chan.write_data;
         req_ff.sda_in           <= req_chan.sda_in;
      end
   end

   i2cram_step u_step (
      .st           (st_ff),
      .pending_byte (pend_ff),
      .req          (req_ff),
      .st_in        (st_in),
      .pend_we      (pend_we),
      .rsp          (rsp_in)
   );

   // bus state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // buffered write byte
   always_ff @(posedge clock) begin
      if (advance && pend_we) begin
         pend_ff <= req_ff.write_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_v_ff;
   assign rsp_chan.scl_level       = rsp_ff.scl_level;
   assign rsp_chan.sda_mode        = rsp_ff.sda_mode;
   assign rsp_chan.read_data       = rsp_ff.read_data;
   assign rsp_chan.read_valid      = rsp_ff.read_valid;
   assign rsp_chan.read_last       = rsp_ff.read_last;
   assign rsp_chan.want_write_byte = rsp_ff.want_write_byte;
   assign rsp_chan.status          = rsp_ff.status;

   // a received byte only ever arrives mid-transaction
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.read_valid |-> rsp_ff.status == STAT_BUSY)
      else $error("received byte outside a busy transaction");

   // last flag never comes without a byte
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.read_last |-> rsp_ff.read_valid)
      else $error("read_last without read_valid");

   // the bus state must not move while a response is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_chan.ready |=> $stable(st_ff))
      else $error("bus state advanced under a stalled response");

   // write bytes are only asked for during a busy write
   a_want_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.want_write_byte |-> rsp_ff.status == STAT_BUSY)
      else $error("write byte requested while not busy");

endmodule
